// ===== hdl/prefix_polynomial_hash_range_query_defines.svh =====
// assertion macros shared by the prefix hash engine
// no dependencies
`ifndef PREFIX_POLYNOMIAL_HASH_RANGE_QUERY_DEFINES_SVH
`define PREFIX_POLYNOMIAL_HASH_RANGE_QUERY_DEFINES_SVH

// same-cycle implication
`define PPHRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PPHRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/pphrq_pkg.sv =====
// types, codes and constants of the prefix hash engine
// no dependencies
package pphrq_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int WORD_W           = 31;
    localparam int VALUE_W          = 32;
    localparam int INDEX_W          = 10;
    localparam int CFG_INDEX_W      = 8;
    localparam int CFG_DATA_W       = 32;
    localparam int DIV_W            = 64;

    localparam logic [WORD_W-1:0] BASE_RESET    = 31'd1000007;
    localparam logic [WORD_W-1:0] MODULUS_RESET = 31'd1000000009;
    localparam logic [WORD_W-1:0] MODULUS_MIN   = 31'd2;
    localparam logic [WORD_W-1:0] PREFIX_ZERO   = 31'd0;
    localparam logic [WORD_W-1:0] POWER_ZERO    = 31'd1;

    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS = 8'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] left;
        logic [INDEX_W-1:0] right;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] hash_value;
        logic [1:0]        status;
    } t_out_word;

    typedef struct packed {
        logic               start;
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
        logic [VALUE_W-1:0] c;
    } t_mm_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } t_mm_rsp;

endpackage

// ===== hdl/pphrq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module pphrq_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1025,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pphrq_modmul.sv =====
// shared modular multiply-add unit: (a*b + c) mod m
// one registered multiply, then a one-bit-per-cycle remainder over 64 bits; uses pphrq_pkg
module pphrq_modmul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pphrq_pkg::t_mm_req                  i_req,
    input  logic [pphrq_pkg::WORD_W-1:0]        i_mod,
    output pphrq_pkg::t_mm_rsp                  o_rsp
);
    import pphrq_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam int PROD_W = 2 * WORD_W;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_LOAD = 2'd1;
    localparam logic [1:0] M_RED  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [PROD_W-1:0] r_prod;
    logic [VALUE_W-1:0] r_c;
    logic [DIV_W-1:0]  r_div, n_div;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   reduced;

    assign shifted = {r_rem, r_div[DIV_W-1]};
    assign reduced = (shifted >= {1'b0, i_mod}) ? (shifted - {1'b0, i_mod}) : shifted;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_div   = r_div;
        n_rem   = r_rem;
        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_state = M_LOAD;
                end
            end
            M_LOAD: begin
                n_div   = DIV_W'(r_prod) + DIV_W'(r_c);
                n_rem   = '0;
                n_cnt   = CNT_W'(DIV_W - 1);
                n_state = M_RED;
            end
            M_RED: begin
                n_rem = reduced[WORD_W-1:0];
                n_div = r_div << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = M_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt <= n_cnt;
        r_div <= n_div;
        r_rem <= n_rem;
        if (r_state == M_IDLE && i_req.start) begin
            r_prod <= i_req.a * i_req.b;
            r_c    <= i_req.c;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_rem;

endmodule

// ===== hdl/prefix_polynomial_hash_range_query.sv =====
// top level of the polynomial prefix hash engine: sequencer, stores and config registers
// uses pphrq_pkg, pphrq_ram, pphrq_modmul and the assertion macro header
// o_in_ready is low while an input word is being handled. An append or an in-range query
// makes two passes through the shared modular unit, each a registered 31x31 multiply
// followed by a 64-step one-bit-per-cycle remainder, plus store reads and the output load.
// A restart, an append to a full store, a bad range or an unused code goes straight to
// the output load. Stored prefix and power words live in two rams of MAX_ELEMENTS+1
// entries, each with one write and one read port; entry zero is supplied as a constant,
// so no clearing pass is needed after reset. The result word sits in an output register;
// the block waits there only if the previous result has not been taken.
module prefix_polynomial_hash_range_query #(
    parameter int MAX_ELEMENTS = pphrq_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pphrq_pkg::t_in_word                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output pphrq_pkg::t_out_word                 o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pphrq_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pphrq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pphrq_pkg::*;

    `include "prefix_polynomial_hash_range_query_defines.svh"

    localparam int AW = $clog2(MAX_ELEMENTS + 1);
    localparam int XW = (AW > INDEX_W + 1) ? AW : INDEX_W + 1;
    localparam logic [AW-1:0] COUNT_FULL = AW'(MAX_ELEMENTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_A_RD  = 4'd1;
    localparam logic [3:0] S_A_PW  = 4'd2;
    localparam logic [3:0] S_A_H   = 4'd3;
    localparam logic [3:0] S_Q_RD1 = 4'd4;
    localparam logic [3:0] S_Q_RD2 = 4'd5;
    localparam logic [3:0] S_Q_SUB = 4'd6;
    localparam logic [3:0] S_Q_FIN = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [WORD_W-1:0]  r_base;
    logic [WORD_W-1:0]  r_mod;
    logic [AW-1:0]      r_count, n_count;
    logic [WORD_W-1:0]  r_opa, n_opa;
    logic [WORD_W-1:0]  r_pw, n_pw;
    logic [WORD_W-1:0]  r_whole, n_whole;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [AW-1:0]      r_rp1, n_rp1;
    t_out_word          r_res, n_res;
    logic               r_out_valid;
    t_out_word          r_out_data;
    logic               r_pf_zero;
    logic               r_pw_zero;

    logic               in_acc;
    logic [XW-1:0]      left_x;
    logic [XW-1:0]      right_x;
    logic [XW-1:0]      count_x;
    logic [XW-1:0]      len_x;
    logic [XW-1:0]      rp1_x;
    logic               bad_range;
    logic [AW-1:0]      pf_raddr;
    logic [AW-1:0]      pw_raddr;
    logic [WORD_W-1:0]  pf_rdata;
    logic [WORD_W-1:0]  pw_rdata;
    logic [WORD_W-1:0]  pf_eff;
    logic [WORD_W-1:0]  pw_eff;
    logic [WORD_W-1:0]  mod_eff;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               out_load;
    t_mm_req            mm_req;
    t_mm_rsp            mm_rsp;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    assign left_x    = XW'(i_in_data.left);
    assign right_x   = XW'(i_in_data.right);
    assign count_x   = XW'(r_count);
    assign len_x     = right_x - left_x + 1'b1;
    assign rp1_x     = right_x + 1'b1;
    assign bad_range = (i_in_data.left > i_in_data.right) || (right_x >= count_x);

    assign mod_eff = (r_mod < MODULUS_MIN) ? MODULUS_MIN : r_mod;
    assign pf_eff  = r_pf_zero ? PREFIX_ZERO : pf_rdata;
    assign pw_eff  = r_pw_zero ? POWER_ZERO : pw_rdata;
    assign wr_addr = r_count + 1'b1;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        pf_raddr = r_count;
        pw_raddr = r_count;
        if (r_state == S_IDLE && i_in_data.operation == OP_QUERY) begin
            pf_raddr = left_x[AW-1:0];
            pw_raddr = len_x[AW-1:0];
        end else if (r_state == S_Q_RD1) begin
            pf_raddr = r_rp1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_opa   = r_opa;
        n_pw    = r_pw;
        n_whole = r_whole;
        n_value = r_value;
        n_rp1   = r_rp1;
        n_res   = r_res;
        wr_en   = 1'b0;
        mm_req  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_value = i_in_data.value;
                    n_rp1   = rp1_x[AW-1:0];
                    n_res   = '{hash_value: '0, status: ST_OK};
                    n_state = S_OUT;
                    case (i_in_data.operation)
                        OP_APPEND: begin
                            if (r_count == COUNT_FULL) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_state = S_A_RD;
                            end
                        end
                        OP_QUERY: begin
                            if (bad_range) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                n_state = S_Q_RD1;
                            end
                        end
                        OP_RESTART: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_A_RD: begin
                n_opa        = pf_eff;
                mm_req.start = 1'b1;
                mm_req.a     = pw_eff;
                mm_req.b     = r_base;
                n_state      = S_A_PW;
            end
            S_A_PW: begin
                if (mm_rsp.done) begin
                    n_pw         = mm_rsp.result;
                    mm_req.start = 1'b1;
                    mm_req.a     = r_opa;
                    mm_req.b     = r_base;
                    mm_req.c     = r_value;
                    n_state      = S_A_H;
                end
            end
            S_A_H: begin
                if (mm_rsp.done) begin
                    wr_en            = 1'b1;
                    n_count          = wr_addr;
                    n_res.hash_value = mm_rsp.result;
                    n_state          = S_OUT;
                end
            end
            S_Q_RD1: begin
                mm_req.start = 1'b1;
                mm_req.a     = pf_eff;
                mm_req.b     = pw_eff;
                n_state      = S_Q_RD2;
            end
            S_Q_RD2: begin
                n_whole = pf_eff;
                n_state = S_Q_SUB;
            end
            S_Q_SUB: begin
                if (mm_rsp.done) begin
                    mm_req.start = 1'b1;
                    mm_req.c     = {1'b0, r_whole} + {1'b0, mod_eff} - {1'b0, mm_rsp.result};
                    n_state      = S_Q_FIN;
                end
            end
            S_Q_FIN: begin
                if (mm_rsp.done) begin
                    n_res.hash_value = mm_rsp.result;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= BASE_RESET;
            r_mod       <= MODULUS_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BASE:    r_base <= i_cfg_data[WORD_W-1:0];
                    CFG_MODULUS: r_mod  <= i_cfg_data[WORD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_opa     <= n_opa;
        r_pw      <= n_pw;
        r_whole   <= n_whole;
        r_value   <= n_value;
        r_rp1     <= n_rp1;
        r_res     <= n_res;
        r_pf_zero <= (pf_raddr == '0);
        r_pw_zero <= (pw_raddr == '0);
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    pphrq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ELEMENTS + 1)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (mm_rsp.result),
        .i_raddr (pf_raddr),
        .o_rdata (pf_rdata)
    );

    pphrq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ELEMENTS + 1)
    ) u_power_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (r_pw),
        .i_raddr (pw_raddr),
        .o_rdata (pw_rdata)
    );

    pphrq_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .i_mod   (mod_eff),
        .o_rsp   (mm_rsp)
    );

    `PPHRQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_in_ready)
    `PPHRQ_ASSERT_NEXT(a_count_steps, i_clk, i_rst_n, wr_en, r_count == $past(wr_addr))
    `PPHRQ_ASSERT_NOW(a_done_expected, i_clk, i_rst_n, mm_rsp.done,
        r_state == S_A_PW || r_state == S_A_H || r_state == S_Q_SUB || r_state == S_Q_FIN)

endmodule
